// ----- src/bcu_pkg.sv -----
package bcu_pkg;

    localparam int MAX_CHOOSE = 64;

    localparam int M_W      = 16;
    localparam int K_W      = 7;
    localparam int COEF_W   = 64;
    localparam int X_W      = M_W + 1;
    localparam int PROD_W   = COEF_W + X_W;
    localparam int MUL_CW   = $clog2(X_W + 1);
    localparam int DIV_CW   = $clog2(PROD_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_START,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- src/bcu_mul.sv -----
module bcu_mul
    import bcu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [COEF_W-1:0]   i_mcand,
    input  logic [X_W-1:0]      i_mplier,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_product
);

    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] n_acc;
    logic [COEF_W-1:0] r_mcand;
    logic [X_W-1:0]    r_mplier;
    logic [MUL_CW-1:0] r_cnt;
    logic              r_run;
    logic              r_done;

    // msb first shift and add, one multiplier bit per cycle
    always_comb begin
        n_acc = {r_acc[PROD_W-2:0], 1'b0};
        if (r_mplier[X_W-1]) begin
            n_acc = n_acc + {{X_W{1'b0}}, r_mcand};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= MUL_CW'(X_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_run) begin
            r_acc    <= n_acc;
            r_mplier <= {r_mplier[X_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ----- src/bcu_div.sv -----
module bcu_div
    import bcu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_dividend,
    input  logic [K_W-1:0]      i_divisor,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_quotient
);

    logic [PROD_W-1:0] r_quo;
    logic [K_W-1:0]    r_rem;
    logic [K_W-1:0]    r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_run;
    logic              r_done;
    logic [K_W:0]      trial;
    logic              fits;

    // restoring division, one dividend bit per cycle
    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CW'(PROD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[PROD_W-2:0], fits};
            if (fits) begin
                r_rem <= K_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[K_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/binomial_coefficient_unit.sv -----
// binomial coefficient C(m,k), 64-bit result with saturation
// command channel: drive i_total_count and i_choose_count with i_start high;
// the beat is taken at a clock edge where o_busy is low. o_busy stays high
// until the result has been shown.
// result channel: o_coefficient and o_overflow are valid for exactly one
// cycle while o_done is high. there is no back pressure; the receiver must
// take the beat in that cycle.
// choose counts above 64 are clamped to 64. zero m or zero k give 1, k > m
// with nonzero m gives 0 and k = m gives 1; these cases go from S_PREP
// straight to S_OUT.
// otherwise the block runs s = min(k, m-k) steps, each a bit-serial multiply
// by (m-s+i) and a bit-serial exact divide by i, with S_START launching the
// multiply of each step. a value above 64 bits stops early with all ones
// and o_overflow high, so at most 34 steps run. a new command is taken the
// cycle after o_done.
// reset (i_rst_n low, synchronous) returns the block to idle and drops
// any item in flight.
module binomial_coefficient_unit
    import bcu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [M_W-1:0]      i_total_count,
    input  logic [K_W-1:0]      i_choose_count,
    output logic                o_done,
    output logic [COEF_W-1:0]   o_coefficient,
    output logic                o_overflow
);

    t_state             r_state;
    t_state             n_state;
    logic [M_W-1:0]     r_m;
    logic [K_W-1:0]     r_k;
    logic [K_W-1:0]     r_steps;
    logic [M_W-1:0]     r_base;
    logic [K_W-1:0]     r_i;
    logic [COEF_W-1:0]  r_val;
    logic               r_ovf;

    logic               accept;
    logic               mul_start;
    logic               div_start;
    logic               mul_done;
    logic               div_done;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  quotient;
    logic [X_W-1:0]     factor;
    logic [M_W-1:0]     diff;
    logic [K_W-1:0]     steps;
    logic               special;
    logic               too_many;
    logic               q_ovf;
    logic               last_step;

    assign accept    = i_start && (r_state == S_IDLE);
    assign diff      = r_m - {{(M_W-K_W){1'b0}}, r_k};
    assign steps     = (diff < {{(M_W-K_W){1'b0}}, r_k}) ? diff[K_W-1:0] : r_k;
    assign special   = (r_m == '0) || (r_k == '0);
    assign too_many  = ({{(M_W-K_W){1'b0}}, r_k} > r_m);
    assign factor    = {1'b0, r_base} + {{(X_W-K_W){1'b0}}, r_i};
    assign q_ovf     = (quotient[PROD_W-1:COEF_W] != '0);
    assign last_step = (r_i == r_steps);

    bcu_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (r_val),
        .i_mplier  (factor),
        .o_done    (mul_done),
        .o_product (product)
    );

    bcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_i),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // k = m needs no steps
                if (special || too_many || (steps == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (q_ovf || last_step) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        o_busy    = 1'b1;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_busy    = 1'b0;
            S_START: mul_start = 1'b1;
            S_MUL:   div_start = mul_done;
            S_OUT:   o_done    = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m <= i_total_count;
            if (i_choose_count > K_W'(MAX_CHOOSE)) begin
                r_k <= K_W'(MAX_CHOOSE);
            end else begin
                r_k <= i_choose_count;
            end
        end
        if (r_state == S_PREP) begin
            r_ovf   <= 1'b0;
            r_i     <= K_W'(1);
            r_steps <= steps;
            r_base  <= r_m - {{(M_W-K_W){1'b0}}, steps};
            if (special) begin
                r_val <= COEF_W'(1);
            end else if (too_many) begin
                r_val <= '0;
            end else begin
                r_val <= COEF_W'(1);
            end
        end
        if ((r_state == S_DIV) && div_done) begin
            if (q_ovf) begin
                r_val <= '1;
                r_ovf <= 1'b1;
            end else begin
                r_val <= quotient[COEF_W-1:0];
                r_i   <= r_i + 1'b1;
            end
        end
    end

    assign o_coefficient = r_val;
    assign o_overflow    = r_ovf;

endmodule
